// ===== hw/rtl/pboftq_pkg.sv =====
// ----------------------------------------------------------------------------
// pboftq_pkg: shared types and constants of the transaction queue
// Sizes, request and status codes, the search wave carried along the slot
// chain, and the rank and bank reduction helpers.
// ----------------------------------------------------------------------------
package pboftq_pkg;

  // Sizing
  localparam int QUEUE_DEPTH = 32;
  localparam int RANK_COUNT  = 2;
  localparam int BANK_COUNT  = 8;
  localparam int ROW_WIDTH   = 16;

  // Fixed field widths
  localparam int RANK_SEL_W = 1;
  localparam int BANK_SEL_W = 3;
  localparam int ROW_IN_W   = 16;
  localparam int TIME_W     = 32;
  localparam int TAG_W      = 16;

  // Derived widths
  localparam int SLOT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int BANKS_N = RANK_COUNT * BANK_COUNT;
  localparam int BIDX_W  = (BANKS_N > 1) ? $clog2(BANKS_N) : 1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_POP    = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } state_e;

  // One request as it travels down the slot chain
  typedef struct packed {
    logic                   valid;
    req_e                   op;
    logic [RANK_SEL_W-1:0]  rank;
    logic [BANK_SEL_W-1:0]  bank;
    logic [SLOT_W-1:0]      sel;
    logic                   found;
    logic [SLOT_W-1:0]      slot;
    logic [TIME_W-1:0]      arr_time;
    logic [TAG_W-1:0]       tag;
    logic [ROW_WIDTH-1:0]   row;
  } wave_t;

  // Rank modulo RANK_COUNT by repeated subtract (narrow value)
  function automatic logic [RANK_SEL_W-1:0] rank_reduce(input logic [RANK_SEL_W-1:0] r);
    logic [RANK_SEL_W-1:0] v;
    v = r;
    for (int k = 0; k < 8; k++) begin
      if (int'(v) >= RANK_COUNT) v = v - RANK_SEL_W'(RANK_COUNT);
    end
    return v;
  endfunction

  // Bank modulo BANK_COUNT by repeated subtract (narrow value)
  function automatic logic [BANK_SEL_W-1:0] bank_reduce(input logic [BANK_SEL_W-1:0] b);
    logic [BANK_SEL_W-1:0] v;
    v = b;
    for (int k = 0; k < 8; k++) begin
      if (int'(v) >= BANK_COUNT) v = v - BANK_SEL_W'(BANK_COUNT);
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/pboftq_cell.sv =====
// ----------------------------------------------------------------------------
// pboftq_cell: one queue slot
// Holds one entry and acts on the request wave as it passes: claims itself
// on insert when free, offers itself as the oldest match on find, and
// hands out and frees its entry on pop. The wave is registered on exit.
// ----------------------------------------------------------------------------
module pboftq_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [pboftq_pkg::SLOT_W-1:0]  slot_num,
  input  pboftq_pkg::wave_t              wave_in,
  output pboftq_pkg::wave_t              wave_out
);
  import pboftq_pkg::*;

  // Stored entry
  logic                   valid;
  logic [RANK_SEL_W-1:0]  ent_rank;
  logic [BANK_SEL_W-1:0]  ent_bank;
  logic [ROW_WIDTH-1:0]   ent_row;
  logic [TIME_W-1:0]      ent_time;
  logic [TAG_W-1:0]       ent_tag;

  wave_t wave_next;
  logic  take_ins;
  logic  take_pop;
  logic  match;

  // Act on the passing wave
  always_comb begin
    wave_next = wave_in;
    take_ins  = 1'b0;
    take_pop  = 1'b0;
    match     = valid && (ent_rank == wave_in.rank) && (ent_bank == wave_in.bank);
    if (wave_in.valid) begin
      unique case (wave_in.op)
        REQ_INSERT: begin
          if (!wave_in.found && !valid) begin
            take_ins        = 1'b1;
            wave_next.found = 1'b1;
            wave_next.slot  = slot_num;
          end
        end
        REQ_FIND: begin
          // strict compare keeps the lower slot on a tie
          if (match && (!wave_in.found || ent_time < wave_in.arr_time)) begin
            wave_next.found    = 1'b1;
            wave_next.slot     = slot_num;
            wave_next.arr_time = ent_time;
          end
        end
        REQ_POP: begin
          if (valid && wave_in.sel == slot_num) begin
            take_pop        = 1'b1;
            wave_next.found = 1'b1;
            wave_next.tag   = ent_tag;
            wave_next.row   = ent_row;
            wave_next.rank  = ent_rank;
            wave_next.bank  = ent_bank;
          end
        end
        default: ;
      endcase
    end
  end

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take_ins) begin
      valid <= 1'b1;
    end else if (take_pop) begin
      valid <= 1'b0;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (take_ins) begin
      ent_rank <= wave_in.rank;
      ent_bank <= wave_in.bank;
      ent_row  <= wave_in.row;
      ent_time <= wave_in.arr_time;
      ent_tag  <= wave_in.tag;
    end
  end

  // Hand the wave to the next slot
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out <= '0;
    end else begin
      wave_out <= wave_next;
    end
  end

  // A claimed slot must have been free; a claim marks the slot and a pop frees it
  a_ins_free: assert property (@(posedge clk) disable iff (rst)
    take_ins |-> !valid) else $error("insert claimed an occupied slot");
  a_ins_sets: assert property (@(posedge clk) disable iff (rst)
    take_ins |=> valid) else $error("insert did not mark slot");
  a_pop_clears: assert property (@(posedge clk) disable iff (rst)
    take_pop |=> !valid) else $error("pop did not free slot");

endmodule

// ===== hw/rtl/per_bank_oldest_first_txn_queue.sv =====
// ----------------------------------------------------------------------------
// per_bank_oldest_first_txn_queue: per-bank oldest-first transaction queue
// Slot-numbered queue with insert, find-oldest and pop requests, and
// row-buffer hit tracking per rank and bank.
// ----------------------------------------------------------------------------
// Each item is taken into the head register. The request then travels down a
// chain of QUEUE_DEPTH slot cells, one cell per cycle. A capture register
// holds the wave as it leaves the chain, and a last step resolves the result,
// updates the per-bank last row and loads the output register, stalling while
// an earlier result is not yet taken. One item is in flight at a time. A new
// item is taken while the previous result still waits on the output. Insert
// goes to the lowest free slot. Find returns the lowest-numbered slot among the
// oldest entries of a rank and bank (0 if none). Pop frees a slot and reports
// a row hit against the last row popped from its bank.
// ----------------------------------------------------------------------------
module per_bank_oldest_first_txn_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          req_type,
  input  logic [pboftq_pkg::RANK_SEL_W-1:0]   rank_sel,
  input  logic [pboftq_pkg::BANK_SEL_W-1:0]   bank_sel,
  input  logic [pboftq_pkg::ROW_IN_W-1:0]     row_addr,
  input  logic [pboftq_pkg::TIME_W-1:0]       arrival_time,
  input  logic [pboftq_pkg::TAG_W-1:0]        txn_tag,
  input  logic [pboftq_pkg::SLOT_W-1:0]       slot_sel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pboftq_pkg::SLOT_W-1:0]       slot_out,
  output logic [pboftq_pkg::TAG_W-1:0]        tag_out,
  output logic                                row_hit,
  output logic                                hit_known,
  output logic [1:0]                          status,
  output logic [pboftq_pkg::SLOT_W-1:0]       used_count
);
  import pboftq_pkg::*;

  state_e state, state_next;
  wave_t  head;
  wave_t  new_wave;
  wave_t  fin;
  wave_t  chain [QUEUE_DEPTH+1];

  logic [SLOT_W-1:0]    occupancy;
  logic [ROW_WIDTH-1:0] last_row [BANKS_N];
  logic [BANKS_N-1:0]   last_row_valid;

  logic launch, capture, finish;

  // Per-item result
  logic [SLOT_W-1:0] res_slot;
  logic [TAG_W-1:0]  res_tag;
  logic              res_hit;
  logic              res_known;
  status_e           res_status;
  logic [SLOT_W-1:0] occ_next;
  logic [BIDX_W-1:0] fin_bidx;
  logic              row_upd;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_RUN;
      end
      S_RUN: begin
        if (chain[QUEUE_DEPTH].valid) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign launch  = in_valid && in_ready;
  assign capture = (state == S_RUN) && chain[QUEUE_DEPTH].valid;
  assign finish  = (state == S_FINISH) && (!out_valid || out_ready);

  // Build the wave from the accepted item
  always_comb begin
    new_wave          = '0;
    new_wave.valid    = 1'b1;
    new_wave.op       = req_e'(req_type);
    new_wave.rank     = rank_reduce(rank_sel);
    new_wave.bank     = bank_reduce(bank_sel);
    new_wave.sel      = slot_sel;
    new_wave.arr_time = arrival_time;
    new_wave.tag      = txn_tag;
    new_wave.row      = ROW_WIDTH'(row_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (launch) begin
      head <= new_wave;
    end else begin
      head.valid <= 1'b0;
    end
  end

  // Slot chain
  assign chain[0] = head;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pboftq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .slot_num (SLOT_W'(i + 1)),
      .wave_in  (chain[i]),
      .wave_out (chain[i+1])
    );
  end

  // Hold the wave leaving the last slot
  always_ff @(posedge clk) begin
    if (capture) fin <= chain[QUEUE_DEPTH];
  end

  // Resolve result and bank row state
  always_comb begin
    fin_bidx   = BIDX_W'(int'(fin.rank) * BANK_COUNT + int'(fin.bank));
    res_slot   = '0;
    res_tag    = '0;
    res_hit    = 1'b0;
    res_known  = 1'b0;
    res_status = ST_OK;
    occ_next   = occupancy;
    row_upd    = 1'b0;
    unique case (fin.op)
      REQ_INSERT: begin
        if (fin.found) begin
          res_slot = fin.slot;
          occ_next = occupancy + SLOT_W'(1);
        end else begin
          res_status = ST_FULL;
        end
      end
      REQ_FIND: begin
        if (fin.found) res_slot = fin.slot;
      end
      REQ_POP: begin
        if (fin.found) begin
          res_tag   = fin.tag;
          res_known = last_row_valid[fin_bidx];
          res_hit   = res_known && (last_row[fin_bidx] == fin.row);
          occ_next  = occupancy - SLOT_W'(1);
          row_upd   = 1'b1;
        end else begin
          res_status = ST_BAD_SLOT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy      <= '0;
      last_row_valid <= '0;
    end else if (finish) begin
      occupancy <= occ_next;
      if (row_upd) last_row_valid[fin_bidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && row_upd) last_row[fin_bidx] <= fin.row;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      slot_out   <= res_slot;
      tag_out    <= res_tag;
      row_hit    <= res_hit;
      hit_known  <= res_known;
      status     <= res_status;
      used_count <= occ_next;
    end
  end

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    int'(occupancy) <= QUEUE_DEPTH) else $error("occupancy above depth");
  a_tail_in_run: assert property (@(posedge clk) disable iff (rst)
    chain[QUEUE_DEPTH].valid |-> state == S_RUN) else $error("stray wave at chain end");
  a_launch_head: assert property (@(posedge clk) disable iff (rst)
    launch |=> head.valid) else $error("accepted item not launched");
  a_full_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> int'(occupancy) == QUEUE_DEPTH)
    else $error("full reported with free slots");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of per_bank_oldest_first_txn_queue
// A table of directed items walks the edge cases of insert, find and pop, then
// phases of random items with varying insert share fill and drain the queue.
// A local predictor keeps its own copy of the slots and the per-bank last row;
// each result is checked field by field, in order, against it or a typed row.
// ----------------------------------------------------------------------------
module tb;
  import pboftq_pkg::*;

  // One request as driven on the input ports
  typedef struct packed {
    req_e                  op;
    logic [RANK_SEL_W-1:0] rank;
    logic [BANK_SEL_W-1:0] bank;
    logic [ROW_IN_W-1:0]   row;
    logic [TIME_W-1:0]     arr;
    logic [TAG_W-1:0]      tag;
    logic [SLOT_W-1:0]     sel;
  } txn_req_t;

  // One result as seen on the output ports
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic              hit;
    logic              known;
    status_e           st;
    logic [SLOT_W-1:0] used;
  } txn_result_t;

  // Directed row: request, and the result when it is typed in by hand
  typedef struct packed {
    txn_req_t    req;
    logic        typed;
    txn_result_t res;
  } stim_row_t;

  localparam int RAND_ITEMS = 1725;
  localparam int PHASES     = 8;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_WAIT = 40;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [1:0]            req_type     = '0;
  logic [RANK_SEL_W-1:0] rank_sel     = '0;
  logic [BANK_SEL_W-1:0] bank_sel     = '0;
  logic [ROW_IN_W-1:0]   row_addr     = '0;
  logic [TIME_W-1:0]     arrival_time = '0;
  logic [TAG_W-1:0]      txn_tag      = '0;
  logic [SLOT_W-1:0]     slot_sel     = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [SLOT_W-1:0]     slot_out;
  logic [TAG_W-1:0]      tag_out;
  logic                  row_hit;
  logic                  hit_known;
  logic [1:0]            status;
  logic [SLOT_W-1:0]     used_count;

  // Predicted queue contents
  bit                    q_valid [1:QUEUE_DEPTH];
  logic [RANK_SEL_W-1:0] q_rank  [1:QUEUE_DEPTH];
  logic [BANK_SEL_W-1:0] q_bank  [1:QUEUE_DEPTH];
  logic [ROW_WIDTH-1:0]  q_row   [1:QUEUE_DEPTH];
  logic [TIME_W-1:0]     q_time  [1:QUEUE_DEPTH];
  logic [TAG_W-1:0]      q_tag   [1:QUEUE_DEPTH];
  logic [ROW_WIDTH-1:0]  open_row   [BANKS_N];
  bit                    open_row_ok[BANKS_N];
  int                    q_used;

  txn_result_t pending_results[$];
  stim_row_t   stim_table[$];
  int          errors    = 0;
  bit          calm      = 1'b0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          ins_share[PHASES] = '{85, 50, 20, 60, 95, 30, 55, 70};

  per_bank_oldest_first_txn_queue i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .rank_sel     (rank_sel),
    .bank_sel     (bank_sel),
    .row_addr     (row_addr),
    .arrival_time (arrival_time),
    .txn_tag      (txn_tag),
    .slot_sel     (slot_sel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .slot_out     (slot_out),
    .tag_out      (tag_out),
    .row_hit      (row_hit),
    .hit_known    (hit_known),
    .status       (status),
    .used_count   (used_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1600000;
    $display("per_bank_oldest_first_txn_queue: mismatch");
    $finish;
  end

  function automatic txn_req_t mk_req(req_e op, int rank, int bank, int row,
                                      logic [31:0] arr, int tag, int sel);
    txn_req_t r;
    r.op   = op;
    r.rank = RANK_SEL_W'(rank);
    r.bank = BANK_SEL_W'(bank);
    r.row  = ROW_IN_W'(row);
    r.arr  = arr;
    r.tag  = TAG_W'(tag);
    r.sel  = SLOT_W'(sel);
    return r;
  endfunction

  function automatic txn_result_t mk_res(int slot, int tag, int hit, int known,
                                         status_e st, int used);
    txn_result_t e;
    e.slot  = SLOT_W'(slot);
    e.tag   = TAG_W'(tag);
    e.hit   = hit[0];
    e.known = known[0];
    e.st    = st;
    e.used  = SLOT_W'(used);
    return e;
  endfunction

  task automatic add_row(txn_req_t r, bit typed, txn_result_t e);
    stim_row_t row;
    row.req   = r;
    row.typed = typed;
    row.res   = e;
    stim_table.push_back(row);
  endtask

  // Queue behavior: apply one request to the local copy, return its result
  task automatic apply_request(input txn_req_t r, output txn_result_t res);
    int rk, bk, bi, s, best;
    logic [TIME_W-1:0] best_t;
    res    = '0;
    rk     = int'(r.rank) % RANK_COUNT;
    bk     = int'(r.bank) % BANK_COUNT;
    best   = 0;
    best_t = '0;
    s      = 0;
    case (r.op)
      REQ_INSERT: begin
        for (int i = QUEUE_DEPTH; i >= 1; i--) if (!q_valid[i]) s = i;
        if (s == 0) begin
          res.st = ST_FULL;
        end else begin
          q_valid[s] = 1'b1;
          q_rank[s]  = RANK_SEL_W'(rk);
          q_bank[s]  = BANK_SEL_W'(bk);
          q_row[s]   = ROW_WIDTH'(r.row);
          q_time[s]  = r.arr;
          q_tag[s]   = r.tag;
          q_used++;
          res.slot = SLOT_W'(s);
        end
      end
      REQ_FIND: begin
        for (int i = 1; i <= QUEUE_DEPTH; i++) begin
          if (q_valid[i] && int'(q_rank[i]) == rk && int'(q_bank[i]) == bk &&
              (best == 0 || q_time[i] < best_t)) begin
            best   = i;
            best_t = q_time[i];
          end
        end
        res.slot = SLOT_W'(best);
      end
      REQ_POP: begin
        s = int'(r.sel);
        if (s == 0 || s > QUEUE_DEPTH || !q_valid[s]) begin
          res.st = ST_BAD_SLOT;
        end else begin
          bi = int'(q_rank[s]) * BANK_COUNT + int'(q_bank[s]);
          res.known = open_row_ok[bi];
          res.hit   = open_row_ok[bi] && open_row[bi] == q_row[s];
          res.tag   = q_tag[s];
          open_row[bi]    = q_row[s];
          open_row_ok[bi] = 1'b1;
          q_valid[s]      = 1'b0;
          q_used--;
        end
      end
      default: ;
    endcase
    res.used = SLOT_W'(q_used);
  endtask

  // Random request; finds and pops are mostly aimed at live entries of the local copy
  function automatic txn_req_t make_request(int ins_pct);
    txn_req_t r;
    int       n, pick;
    int       occ[$];
    r.op   = REQ_NONE;
    r.rank = RANK_SEL_W'($urandom);
    r.bank = BANK_SEL_W'($urandom);
    r.row  = ($urandom_range(1) == 0) ? ROW_IN_W'($urandom_range(3)) : ROW_IN_W'($urandom);
    r.arr  = ($urandom_range(1) == 0) ? TIME_W'($urandom_range(15)) : $urandom;
    r.tag  = TAG_W'($urandom);
    r.sel  = SLOT_W'($urandom);
    for (int i = 1; i <= QUEUE_DEPTH; i++) if (q_valid[i]) occ.push_back(i);
    n = $urandom_range(99);
    if (n < 6) begin
      // noise: unused code or a pop at any slot number
      if (n >= 3) r.op = REQ_POP;
    end else if ($urandom_range(99) < ins_pct) begin
      r.op = REQ_INSERT;
    end else if ($urandom_range(1) == 0) begin
      r.op = REQ_FIND;
      if (occ.size() != 0 && $urandom_range(3) != 0) begin
        pick   = occ[$urandom_range(occ.size() - 1)];
        r.rank = q_rank[pick];
        r.bank = q_bank[pick];
      end
    end else begin
      r.op = REQ_POP;
      if (occ.size() != 0 && $urandom_range(6) != 0)
        r.sel = SLOT_W'(occ[$urandom_range(occ.size() - 1)]);
    end
    return r;
  endfunction

  // Offer one item, wait for acceptance, record its expected result
  task automatic send_item(input txn_req_t r, input bit typed, input txn_result_t e);
    txn_result_t res;
    in_valid     <= 1'b1;
    req_type     <= r.op;
    rank_sel     <= r.rank;
    bank_sel     <= r.bank;
    row_addr     <= r.row;
    arrival_time <= r.arr;
    txn_tag      <= r.tag;
    slot_sel     <= r.sel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_request(r, res);
    pending_results.push_back(typed ? e : res);
    // random gap, sometimes long enough to land anywhere in the work
    if (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 45)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic note_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    txn_result_t want, got;
    got = '{slot_out, tag_out, row_hit, hit_known, status_e'(status), used_count};
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing expected: slot %0d tag %0d status %0d used %0d",
               $time, got.slot, got.tag, got.st, got.used);
      errors++;
    end else begin
      want = pending_results.pop_front();
      note_field("slot_out", want.slot, got.slot);
      note_field("tag_out", want.tag, got.tag);
      note_field("row_hit", want.hit, got.hit);
      note_field("hit_known", want.known, got.known);
      note_field("status", want.st, got.st);
      note_field("used_count", want.used, got.used);
    end
  endtask

  // Result side: check, then pick the next ready level
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        // long hold-off so the block fills and stalls its input
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  // Stimulus
  initial begin
    txn_req_t r;
    int       sent;

    // directed: empty queue, bad slots, extremes, ties, hits, lowest free slot
    add_row(mk_req(REQ_FIND, 0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, ST_OK, 0));
    add_row(mk_req(REQ_POP, 0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, ST_BAD_SLOT, 0));
    add_row(mk_req(REQ_POP, 1, 7, 0, 0, 0, 32), 1, mk_res(0, 0, 0, 0, ST_BAD_SLOT, 0));
    add_row(mk_req(REQ_POP, 0, 0, 0, 0, 0, 63), 1, mk_res(0, 0, 0, 0, ST_BAD_SLOT, 0));
    add_row(mk_req(REQ_NONE, 1, 7, 'hFFFF, 'hFFFF_FFFF, 'hFFFF, 63), 1,
            mk_res(0, 0, 0, 0, ST_OK, 0));
    add_row(mk_req(REQ_INSERT, 1, 7, 'hFFFF, 'hFFFF_FFFF, 'hFFFF, 63), 1,
            mk_res(1, 0, 0, 0, ST_OK, 1));
    add_row(mk_req(REQ_INSERT, 0, 0, 0, 0, 0, 0), 1, mk_res(2, 0, 0, 0, ST_OK, 2));
    add_row(mk_req(REQ_INSERT, 1, 7, 'hFFFF, 'hFFFF_FFFF, 'h1234, 0), 1,
            mk_res(3, 0, 0, 0, ST_OK, 3));
    add_row(mk_req(REQ_FIND, 1, 7, 0, 0, 0, 0), 1, mk_res(1, 0, 0, 0, ST_OK, 3));
    add_row(mk_req(REQ_INSERT, 1, 7, 0, 5, 'hA5A5, 0), 0, '0);
    add_row(mk_req(REQ_FIND, 1, 7, 0, 0, 0, 0), 1, mk_res(4, 0, 0, 0, ST_OK, 4));
    add_row(mk_req(REQ_POP, 0, 0, 0, 0, 0, 4), 1, mk_res(0, 'hA5A5, 0, 0, ST_OK, 3));
    add_row(mk_req(REQ_POP, 0, 0, 0, 0, 0, 1), 1, mk_res(0, 'hFFFF, 0, 1, ST_OK, 2));
    add_row(mk_req(REQ_POP, 0, 0, 0, 0, 0, 3), 1, mk_res(0, 'h1234, 1, 1, ST_OK, 1));
    add_row(mk_req(REQ_POP, 0, 0, 0, 0, 0, 3), 1, mk_res(0, 0, 0, 0, ST_BAD_SLOT, 1));
    add_row(mk_req(REQ_INSERT, 0, 3, 'h8001, 'h8000_0000, 'h5555, 0), 1,
            mk_res(1, 0, 0, 0, ST_OK, 2));
    add_row(mk_req(REQ_FIND, 0, 0, 0, 0, 0, 0), 1, mk_res(2, 0, 0, 0, ST_OK, 2));
    add_row(mk_req(REQ_FIND, 1, 3, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, ST_OK, 2));
    add_row(mk_req(REQ_POP, 0, 0, 0, 0, 0, 2), 1, mk_res(0, 0, 0, 0, ST_OK, 1));
    add_row(mk_req(REQ_POP, 0, 0, 0, 0, 0, 1), 1, mk_res(0, 'h5555, 0, 0, ST_OK, 0));
    add_row(mk_req(REQ_INSERT, 0, 3, 'h8001, 7, 'h2AAA, 0), 1, mk_res(1, 0, 0, 0, ST_OK, 1));
    add_row(mk_req(REQ_POP, 0, 0, 0, 0, 0, 1), 1, mk_res(0, 'h2AAA, 1, 1, ST_OK, 0));
    add_row(mk_req(REQ_FIND, 0, 3, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, ST_OK, 0));

    for (int i = 1; i <= QUEUE_DEPTH; i++) q_valid[i] = 1'b0;
    foreach (open_row_ok[b]) open_row_ok[b] = 1'b0;
    q_used = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[k]) send_item(stim_table[k].req, stim_table[k].typed,
                                      stim_table[k].res);

    // random phases; insert share moves the queue between empty and full
    hold_req <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      calm <= (p == 3);
      sent = 0;
      while (sent < RAND_ITEMS / PHASES) begin
        r = make_request(ins_share[p]);
        send_item(r, 1'b0, '0);
        if (r.op != REQ_NONE) sent++;
      end
    end
    calm     <= 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("per_bank_oldest_first_txn_queue: match");
    end else begin
      $display("per_bank_oldest_first_txn_queue: mismatch");
    end
    $finish;
  end

endmodule
